// ----- hw/rtl/hmpc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the Holm middle p-value combiner.
package hmpc_pkg;

  localparam int unsigned NumContrastsDef = 8;
  localparam int unsigned FracBitsDef     = 24;
  localparam int unsigned ValW            = 32;
  localparam int unsigned FracW           = 17;
  localparam int unsigned CntW            = 5;
  localparam int unsigned IdxW            = 4;
  localparam int unsigned LnMax           = 16;
  localparam logic [FracW-1:0] FracReset  = 17'd32768;

  typedef enum logic {
    CfgLogMode        = 1'b0,
    CfgMiddleFraction = 1'b1
  } cfg_idx_e;

  // control group traveling alongside each request
  typedef struct packed {
    logic             log_mode;
    logic [FracW-1:0] frac;
    logic [CntW-1:0]  cnt;
    logic [IdxW-1:0]  jump;
  } side_t;

  // ln(n) * 2^32, rounded
  localparam logic [34:0] LnQ32 [LnMax+1] = '{
    35'd0,           35'd0,           35'd2977044472,  35'd4718503851,
    35'd5954088944,  35'd6912483199,  35'd7695548323,  35'd8357620451,
    35'd8931133415,  35'd9437007702,  35'd9889527671,  35'd10298881776,
    35'd10672592794, 35'd11016373606, 35'd11334664923, 35'd11630987050,
    35'd11908177887
  };

  // ascending order key; missing entries sort last
  function automatic logic [ValW:0] sort_key(input logic miss, input logic [ValW-1:0] v);
    return {miss, ~v[ValW-1], v[ValW-2:0]};
  endfunction

  // ln(n) rounded half-up to the value format, sh = 32 - fraction bits
  function automatic logic [33:0] ln_fixed(input logic [CntW-1:0] n, input int unsigned sh);
    logic [CntW-1:0] nn;
    logic [35:0]     t;
    nn = (n > CntW'(LnMax)) ? CntW'(LnMax) : n;
    t  = 36'(LnQ32[nn]) + (36'd1 << (sh - 1));
    return 34'(t >> sh);
  endfunction

  function automatic logic signed [ValW-1:0] sat_val(input logic signed [37:0] x);
    if (x > 38'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -38'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return x[ValW-1:0];
  endfunction

endpackage

// ----- hw/rtl/hmpc_if.sv -----
// Request and response channel interfaces of the Holm middle p-value combiner.
interface hmpc_req_if #(
  parameter int unsigned NumContrasts = 8
);
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       p_value [NumContrasts];
  logic [NumContrasts-1:0]  missing_mask;

  modport source (output valid, p_value, missing_mask, input ready);
  modport sink   (input valid, p_value, missing_mask, output ready);
endinterface

interface hmpc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] combined_value;
  logic               all_missing;

  modport source (output valid, combined_value, all_missing, input ready);
  modport sink   (input valid, combined_value, all_missing, output ready);
endinterface

// ----- hw/rtl/holm_middle_pvalue_combine.sv -----
// Top level of the Holm middle p-value combiner: config, stage control, output register.
//
// Usage:
//   req_i carries one gene per request: NUM_CONTRASTS Q8.24 p-values and a
//   missing mask. rsp_o returns one result per request, in order: the chosen
//   Holm-adjusted value (capped at 1.0, or 0 in log mode) and all_missing.
//   Both channels move a request when valid and ready are high at a clock edge.
// Stages: an input register, one sorting round per contrast, the scaling
//   stage, one prefix-max level per doubling, and the output register.
// Throughput: one request per cycle while req_i.ready is high; every stage
//   holds its own valid bit and empty stages fill even while the output waits.
// Stall: when rsp_o.ready is low the result stays in the output register and
//   the stages behind it fill up; req_i.ready falls only when all are full.
// Config: cfg_we_i writes log_mode or middle_fraction; each request samples
//   them when accepted. Write them only while the pipeline is empty.
// Reset: rst_ni clears all valid bits; log_mode = 0, middle_fraction = 0.5.
module holm_middle_pvalue_combine #(
  parameter int unsigned NumContrasts = hmpc_pkg::NumContrastsDef,
  parameter int unsigned FracBits     = hmpc_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hmpc_req_if.sink                      req_i,
  hmpc_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  hmpc_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [hmpc_pkg::FracW-1:0]    cfg_wdata_i
);
  import hmpc_pkg::*;

  localparam int unsigned Lvls = $clog2(NumContrasts);
  localparam int unsigned NStg = NumContrasts + Lvls + 3;
  localparam int unsigned SelW = $clog2(NumContrasts);
  localparam logic signed [ValW-1:0] OneVal = ValW'(64'd1 << FracBits);

  logic             log_q;
  logic [FracW-1:0] frac_q;

  logic [NStg-1:0]  v_q;
  logic [NStg-1:0]  en;

  side_t                  side_in;
  logic signed [ValW-1:0] sort_val  [NumContrasts];
  side_t                  sort_side;
  logic signed [ValW-1:0] max_val   [NumContrasts];
  side_t                  max_side;

  logic signed [ValW-1:0] chosen;
  logic signed [ValW-1:0] out_val_d, out_val_q;
  logic                   out_miss_d, out_miss_q;
  logic                   out_log_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_q  <= 1'b0;
      frac_q <= FracReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLogMode:        log_q  <= cfg_wdata_i[0];
        CfgMiddleFraction: frac_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || rsp_o.ready;
    for (int s = NStg - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= req_i.valid;
      end
      for (int s = 1; s < NStg; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign req_i.ready = en[0];

  always_comb begin
    side_in          = '0;
    side_in.log_mode = log_q;
    side_in.frac     = frac_q;
    for (int c = 0; c < NumContrasts; c++) begin
      side_in.cnt = side_in.cnt + CntW'(!req_i.missing_mask[c]);
    end
  end

  hmpc_sort #(
    .NumContrasts (NumContrasts)
  ) u_sort (
    .clk_i     (clk_i),
    .en_i      (en[NumContrasts:0]),
    .p_value_i (req_i.p_value),
    .missing_i (req_i.missing_mask),
    .side_i    (side_in),
    .val_o     (sort_val),
    .side_o    (sort_side)
  );

  hmpc_adjust #(
    .NumContrasts (NumContrasts),
    .FracBits     (FracBits)
  ) u_adjust (
    .clk_i  (clk_i),
    .en_i   (en[NumContrasts+Lvls+1:NumContrasts+1]),
    .val_i  (sort_val),
    .side_i (sort_side),
    .val_o  (max_val),
    .side_o (max_side)
  );

  always_comb begin
    chosen     = max_val[max_side.jump[SelW-1:0]];
    out_miss_d = (max_side.cnt == '0);
    out_val_d  = chosen;
    if (max_side.log_mode) begin
      if (chosen > 0) begin
        out_val_d = '0;
      end
    end else if (chosen > OneVal) begin
      out_val_d = OneVal;
    end
    if (out_miss_d) begin
      out_val_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NStg-1]) begin
      out_val_q  <= out_val_d;
      out_miss_q <= out_miss_d;
      out_log_q  <= max_side.log_mode;
    end
  end

  assign rsp_o.valid          = v_q[NStg-1];
  assign rsp_o.combined_value = out_val_q;
  assign rsp_o.all_missing    = out_miss_q;

  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.all_missing |-> rsp_o.combined_value == '0)
    else $error("all-missing result not zero");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (out_log_q && rsp_o.combined_value <= 0) ||
                    (!out_log_q && rsp_o.combined_value <= OneVal &&
                     rsp_o.combined_value >= 0))
    else $error("result outside capped range");

  a_free_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("input stalled with empty output register");

endmodule

// ----- hw/rtl/hmpc_sort.sv -----
// Input register and odd-even transposition sorting network, one round per stage.
module hmpc_sort #(
  parameter int unsigned NumContrasts = 8
) (
  input  logic                      clk_i,
  input  logic [NumContrasts:0]     en_i,
  input  logic signed [31:0]        p_value_i [NumContrasts],
  input  logic [NumContrasts-1:0]   missing_i,
  input  hmpc_pkg::side_t           side_i,
  output logic signed [31:0]        val_o [NumContrasts],
  output hmpc_pkg::side_t           side_o
);
  import hmpc_pkg::*;

  logic signed [ValW-1:0]  val_q  [NumContrasts+1][NumContrasts];
  logic [NumContrasts-1:0] miss_q [NumContrasts+1];
  side_t                   side_q [NumContrasts+1];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      val_q[0]  <= p_value_i;
      miss_q[0] <= missing_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar r = 1; r <= NumContrasts; r++) begin : g_round
    logic signed [ValW-1:0]  val_d [NumContrasts];
    logic [NumContrasts-1:0] miss_d;

    always_comb begin
      val_d  = val_q[r-1];
      miss_d = miss_q[r-1];
      for (int j = ((r - 1) & 1); j + 1 < NumContrasts; j += 2) begin
        if (sort_key(miss_q[r-1][j], val_q[r-1][j]) >
            sort_key(miss_q[r-1][j+1], val_q[r-1][j+1])) begin
          val_d[j]    = val_q[r-1][j+1];
          val_d[j+1]  = val_q[r-1][j];
          miss_d[j]   = miss_q[r-1][j+1];
          miss_d[j+1] = miss_q[r-1][j];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[r]) begin
        val_q[r]  <= val_d;
        miss_q[r] <= miss_d;
        side_q[r] <= side_q[r-1];
      end
    end
  end

  assign val_o  = val_q[NumContrasts];
  assign side_o = side_q[NumContrasts];

endmodule

// ----- hw/rtl/hmpc_adjust.sv -----
// Holm scaling per rank, saturation, pick index, then a registered prefix maximum.
module hmpc_adjust #(
  parameter int unsigned NumContrasts = 8,
  parameter int unsigned FracBits     = 24,
  localparam int unsigned Lvls        = $clog2(NumContrasts)
) (
  input  logic                 clk_i,
  input  logic [Lvls:0]        en_i,
  input  logic signed [31:0]   val_i [NumContrasts],
  input  hmpc_pkg::side_t      side_i,
  output logic signed [31:0]   val_o [NumContrasts],
  output hmpc_pkg::side_t      side_o
);
  import hmpc_pkg::*;

  localparam int unsigned Sh = 32 - FracBits;
  localparam int unsigned JW = CntW + FracW + 1;

  logic [CntW-1:0]         mult  [NumContrasts];
  logic signed [37:0]      prod  [NumContrasts];
  logic signed [33:0]      lsum  [NumContrasts];
  logic signed [ValW-1:0]  adj_d [NumContrasts];
  logic [CntW+FracW-1:0]   jprod;
  logic [JW-1:0]           jsum;
  logic [CntW+1:0]         cj;
  logic [CntW+1:0]         cj_lim;
  side_t                   side_d;

  logic signed [ValW-1:0]  max_q  [Lvls+1][NumContrasts];
  side_t                   side_q [Lvls+1];

  always_comb begin
    for (int i = 0; i < NumContrasts; i++) begin
      mult[i] = side_i.cnt - CntW'(i);
      prod[i] = val_i[i] * $signed({1'b0, mult[i]});
      lsum[i] = {{2{val_i[i][ValW-1]}}, val_i[i]} + $signed(ln_fixed(mult[i], Sh));
      if (side_i.log_mode) begin
        adj_d[i] = sat_val({{4{lsum[i][33]}}, lsum[i]});
      end else begin
        adj_d[i] = sat_val(prod[i]);
        if (adj_d[i] < 0) begin
          adj_d[i] = '0;
        end
      end
    end
  end

  // index ceil(k * fraction) - 1, not below 0 and limited to k - 1
  always_comb begin
    jprod  = side_i.cnt * side_i.frac;
    jsum   = JW'(jprod) + JW'(17'h0FFFF);
    cj     = jsum[JW-1:FracW-1];
    cj_lim = (CntW+2)'(side_i.cnt) - (CntW+2)'(1);
    if (cj != '0) begin
      cj = cj - (CntW+2)'(1);
    end
    if (cj > cj_lim) begin
      cj = cj_lim;
    end
    side_d      = side_i;
    side_d.jump = cj[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      max_q[0]  <= adj_d;
      side_q[0] <= side_d;
    end
  end

  for (genvar l = 1; l <= Lvls; l++) begin : g_lvl
    localparam int unsigned Dist = 1 << (l - 1);
    logic signed [ValW-1:0] max_d [NumContrasts];

    for (genvar i = 0; i < NumContrasts; i++) begin : g_lane
      if (i >= Dist) begin : g_cmp
        assign max_d[i] = (max_q[l-1][i-Dist] > max_q[l-1][i]) ?
                          max_q[l-1][i-Dist] : max_q[l-1][i];
      end else begin : g_pass
        assign max_d[i] = max_q[l-1][i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[l]) begin
        max_q[l]  <= max_d;
        side_q[l] <= side_q[l-1];
      end
    end
  end

  assign val_o  = max_q[Lvls];
  assign side_o = side_q[Lvls];

endmodule

// ----- verif/holm_middle_pvalue_combine_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the Holm middle p-value combiner: per-gene prediction and ordered compare.
module holm_middle_pvalue_combine_tb;

  localparam int NC            = hmpc_pkg::NumContrastsDef;
  localparam int FracBits      = hmpc_pkg::FracBitsDef;
  localparam int FracW         = hmpc_pkg::FracW;
  localparam int LatencyCycles = NC + $clog2(NC) + 3;
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 80;
  localparam int NumPhases     = 12;
  localparam int GenesPerPhase = 112;
  localparam int RandFrac      = 1 << FracW;
  localparam int LnShift       = 32 - FracBits;
  localparam int One           = 1 << FracBits;
  localparam int IntMax        = 32'sh7FFF_FFFF;
  localparam int IntMin        = 32'sh8000_0000;

  // ln(n) scaled by 2^32
  localparam longint unsigned LnNat32 [17] = '{
    64'd0,           64'd0,           64'd2977044472,  64'd4718503851,
    64'd5954088944,  64'd6912483199,  64'd7695548323,  64'd8357620451,
    64'd8931133415,  64'd9437007702,  64'd9889527671,  64'd10298881776,
    64'd10672592794, 64'd11016373606, 64'd11334664923, 64'd11630987050,
    64'd11908177887
  };

  localparam bit PhaseLog  [NumPhases] = '{0, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
  localparam int PhaseFrac [NumPhases] = '{32768, 0, 32768, 65536, 0, 131071, 65536, 1,
                                           131071, RandFrac, 65535, RandFrac};

  typedef struct {
    logic signed [31:0] pv [NC];
    logic [NC-1:0]      mask;
  } gene_t;

  typedef struct {
    int value;
    bit all_missing;
  } result_t;

  class holm_scoreboard;
    bit             log_mode;
    bit [FracW-1:0] frac;
    result_t        pending_adjusted [$];
    int             mismatches;
    int             noted;
    int             checked;
    int             all_missing_seen;

    function new();
      log_mode = 1'b0;
      frac     = hmpc_pkg::FracReset;
    endfunction

    function longint clamp_q(longint v);
      if (v > longint'(IntMax)) return longint'(IntMax);
      if (v < longint'(IntMin)) return longint'(IntMin);
      return v;
    endfunction

    function result_t holm_middle_adjust(gene_t g);
      longint          adj [NC];
      longint          x;
      longint          p;
      longint          floor_v;
      longint unsigned idx;
      int              k;
      int              j;
      int              n;
      result_t         r;
      k = 0;
      for (int c = 0; c < NC; c++) begin
        if (!g.mask[c]) begin
          adj[k] = longint'(g.pv[c]);
          k++;
        end
      end
      if (k == 0) begin
        r.value       = 0;
        r.all_missing = 1'b1;
        return r;
      end
      for (int i = 1; i < k; i++) begin
        x = adj[i];
        j = i;
        while (j > 0 && adj[j-1] > x) begin
          adj[j] = adj[j-1];
          j--;
        end
        adj[j] = x;
      end
      // running max; plain mode floors at zero
      floor_v = log_mode ? longint'(IntMin) : 0;
      for (int i = 0; i < k; i++) begin
        n = (k - i > 16) ? 16 : k - i;
        if (log_mode) begin
          p = clamp_q(adj[i] +
                      longint'((LnNat32[n] + (64'd1 << (LnShift - 1))) >> LnShift));
        end else begin
          p = clamp_q(adj[i] * (k - i));
        end
        if (p < floor_v) begin
          p = floor_v;
        end else begin
          floor_v = p;
        end
        adj[i] = p;
      end
      idx = (longint'(k) * frac + 65535) >> 16;
      if (idx > 0) idx--;
      if (idx > k - 1) idx = k - 1;
      x = adj[idx];
      if (log_mode) begin
        if (x > 0) x = 0;
      end else if (x > One) begin
        x = One;
      end
      r.value       = int'(x);
      r.all_missing = 1'b0;
      return r;
    endfunction

    function void note_gene(gene_t g);
      pending_adjusted.push_back(holm_middle_adjust(g));
      noted++;
    endfunction

    function void check_result(logic signed [31:0] value, logic flag);
      result_t want;
      if (pending_adjusted.size() == 0) begin
        if (mismatches < 10) $display("mismatch: unexpected result %h all_missing %b", value, flag);
        mismatches++;
        return;
      end
      want = pending_adjusted.pop_front();
      checked++;
      if (want.all_missing) all_missing_seen++;
      if (value !== want.value || flag !== want.all_missing) begin
        if (mismatches < 10) begin
          $display("mismatch: result %0d expected value %h all_missing %0b, got %h %b",
                   checked, want.value, want.all_missing, value, flag);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  hmpc_pkg::cfg_idx_e  cfg_idx;
  logic [FracW-1:0]    cfg_wdata;
  bit                  send_idle = 1'b1;
  bit                  rsp_idle  = 1'b1;
  bit                  hold_rsp  = 1'b0;
  int                  settings  = 0;
  holm_scoreboard      sb = new();

  hmpc_req_if #(.NumContrasts(NC)) req_if ();
  hmpc_rsp_if                      rsp_if ();

  holm_middle_pvalue_combine #(
    .NumContrasts(NC),
    .FracBits    (FracBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    gene_t g;
    if (rst_ni && req_if.valid && req_if.ready) begin
      g.pv   = req_if.p_value;
      g.mask = req_if.missing_mask;
      sb.note_gene(g);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.combined_value, rsp_if.all_missing);
    end
  end

  // result side backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_rsp) begin
        hold_rsp     = 1'b0;
        stall_left   = HoldCycles - 1;
        rsp_if.ready <= 1'b0;
      end else if (rsp_idle && $urandom_range(0, 6) == 0) begin
        stall_left   = $urandom_range(0, 3);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("holm_middle_pvalue_combine_tb: errors");
    $finish;
  end

  function automatic gene_t gene_of(int v [NC], logic [NC-1:0] m);
    gene_t g;
    for (int c = 0; c < NC; c++) g.pv[c] = v[c];
    g.mask = m;
    return g;
  endfunction

  function automatic int rand_pvalue(bit lm);
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: return IntMax;
          1: return IntMin;
          2: return 0;
          3: return One;
          4: return -1;
          default: return One + 1;
        endcase
      end
      2: return $urandom_range(0, 255);
      default: begin
        if (lm) return -int'($urandom_range(0, 32'h0A00_0000));
        return int'($urandom_range(0, One) >> $urandom_range(0, 10));
      end
    endcase
  endfunction

  function automatic gene_t rand_gene(bit lm);
    gene_t g;
    for (int c = 0; c < NC; c++) begin
      g.pv[c] = (c > 0 && $urandom_range(0, 7) == 0) ? g.pv[c-1] : rand_pvalue(lm);
    end
    case ($urandom_range(0, 15))
      0: g.mask = '1;
      1: g.mask = '0;
      2: g.mask = ~(NC'(1) << $urandom_range(0, NC - 1));
      default: g.mask = $urandom_range(0, (1 << NC) - 1);
    endcase
    return g;
  endfunction

  task automatic send_gene(gene_t g);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.p_value      <= g.pv;
    req_if.missing_mask <= g.mask;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_adjusted.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(bit lm, logic [FracW-1:0] fr);
    cfg_we    <= 1'b1;
    cfg_idx   <= hmpc_pkg::CfgLogMode;
    cfg_wdata <= FracW'(lm);
    @(posedge clk_i);
    cfg_idx   <= hmpc_pkg::CfgMiddleFraction;
    cfg_wdata <= fr;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    sb.log_mode = lm;
    sb.frac     = fr;
    settings++;
  endtask

  initial begin
    bit               lm;
    logic [FracW-1:0] fr;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= hmpc_pkg::CfgLogMode;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.p_value      <= '{default: '0};
    req_if.missing_mask <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain mode, fraction one half (reset values)
    send_gene(gene_of('{NC{32'h1234_5678}}, 8'hFF));
    send_gene(gene_of('{NC{0}}, 8'h00));
    send_gene(gene_of('{NC{One}}, 8'h00));
    send_gene(gene_of('{NC{IntMax}}, 8'h00));
    send_gene(gene_of('{NC{IntMin}}, 8'h00));
    send_gene(gene_of('{1 << 16, 2 << 16, 3 << 16, 4 << 16, 5 << 16, 6 << 16, 7 << 16,
                        8 << 16}, 8'h00));
    send_gene(gene_of('{8 << 18, 7 << 18, 6 << 18, 5 << 18, 4 << 18, 3 << 18, 2 << 18,
                        1 << 18}, 8'hA5));
    send_gene(gene_of('{0, 0, 0, 0, 0, 0, 0, 32'h0012_3456}, 8'h7F));
    send_gene(gene_of('{-1, 5, 5, 5, 5, 5, 5, 5}, 8'hFE));
    send_gene(gene_of('{NC{32'h0010_0000}}, 8'h0F));
    send_gene(gene_of('{-(5 << 24), 3 << 20, 0, -1, 1, One, IntMax, IntMin}, 8'h00));
    send_gene(gene_of('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
                      8'h00));
    send_gene(gene_of('{NC{32'h2000_0000}}, 8'h00));
    send_gene(gene_of('{3 << 20, 1 << 20, 9, 9, 9, 9, 9, 9}, 8'hFC));

    // log mode, fraction one
    wait_drained();
    configure(1'b1, 17'd65536);
    send_gene(gene_of('{NC{-1}}, 8'hFF));
    send_gene(gene_of('{NC{0}}, 8'h00));
    send_gene(gene_of('{NC{IntMin}}, 8'h00));
    send_gene(gene_of('{IntMax, -(1 << 24), 0, 0, 0, 0, 0, 0}, 8'h00));
    send_gene(gene_of('{-(1 << 24), -(2 << 24), -(3 << 24), -(4 << 24), -(5 << 24),
                        -(6 << 24), -(7 << 24), -(8 << 24)}, 8'h00));
    send_gene(gene_of('{-7, -(1 << 26), -(3 << 23), -1, -(1 << 20), IntMin, -5, 0},
                      8'h3C));

    // fraction zero, then above one
    wait_drained();
    configure(1'b0, 17'd0);
    send_gene(gene_of('{1 << 20, 2 << 20, 3 << 20, 4 << 20, 5 << 20, 6 << 20, 7 << 20,
                        8 << 20}, 8'h00));
    wait_drained();
    configure(1'b0, 17'd131071);
    send_gene(gene_of('{1 << 20, 2 << 20, 3 << 20, 4 << 20, 5 << 20, 6 << 20, 7 << 20,
                        8 << 20}, 8'h00));
    send_gene(gene_of('{1 << 21, 2 << 17, 3 << 19, 4 << 16, 5 << 18, 6 << 15, 7 << 14,
                        8 << 21}, 8'h81));

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      if (PhaseFrac[ph] == RandFrac) begin
        lm = $urandom_range(0, 1);
        fr = $urandom_range(0, 65536);
      end else begin
        lm = PhaseLog[ph];
        fr = PhaseFrac[ph];
      end
      configure(lm, fr);
      send_idle = (ph < NumPhases - 2);
      rsp_idle  = (ph < NumPhases - 2);
      for (int n = 0; n < GenesPerPhase; n++) begin
        if (ph == 1 && n == 30) hold_rsp = 1'b1;
        if (ph == 3 && n == 60) wait_drained();
        send_gene(rand_gene(lm));
      end
    end

    wait_drained();
    repeat (LatencyCycles + 4) @(posedge clk_i);
    $display("summary: %0d genes over %0d register settings, %0d results checked, %0d all-missing",
             sb.noted, settings, sb.checked, sb.all_missing_seen);
    $display("summary: %0d mismatches; plain and log modes, fractions 0 to 131071, long stall",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_adjusted.size() == 0) begin
      $display("holm_middle_pvalue_combine_tb: clean");
    end else begin
      $display("holm_middle_pvalue_combine_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hmpc_pkg.sv
hw/rtl/hmpc_if.sv
hw/rtl/hmpc_sort.sv
hw/rtl/hmpc_adjust.sv
hw/rtl/holm_middle_pvalue_combine.sv
verif/holm_middle_pvalue_combine_tb.sv
